@@ rtl/core/whole_word_search_line_stats_defines.svh @@
// Assertion macros used by the whole-word search result queue.
`ifndef WHOLE_WORD_SEARCH_LINE_STATS_DEFINES_SVH
`define WHOLE_WORD_SEARCH_LINE_STATS_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define WWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define WWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wws_pkg.sv @@
// Shared constants, types and helpers for the whole-word search block.
package wws_pkg;

  localparam int DEF_MAX_WORD_CHARS = 16;
  localparam int DEF_CHUNK_BYTES    = 99;
  localparam int DEF_COUNT_BITS     = 20;

  localparam int POS_BITS      = 5;
  localparam int LEN_BITS      = 7;
  localparam int WIDX_BITS     = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;
  localparam int CHARS_BITS    = 128;

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = 2;
  localparam int OQ_CNT_BITS = 3;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic ACT_BYTE     = 1'b0;
  localparam logic ACT_END      = 1'b1;
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WORD_LENGTH = 2'd0,
    CFG_CHARS_LOW   = 2'd1,
    CFG_CHARS_HIGH  = 2'd2
  } cfg_idx_t;

  // Results pushed toward the output queue in one cycle; v1 only with v0.
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  // Payload width in bits for a result word, rounded up to whole bytes, derived from the counter width.
  function automatic int data_bits(input int count_bits);
    return ((4 * count_bits + WIDX_BITS + LEN_BITS + 7) / 8) * 8;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

endpackage

@@ rtl/core/whole_word_search_line_stats.sv @@
// With an empty queue, the first result word of an accepted input word shows on the output in the next cycle.
// Throughput: one text byte per cycle while in_tready is high; end of input with a pending match yields two words.
// The four-word result queue drops in_tready once it holds more than two words.
// Reset (rst_n low, synchronous) clears all counters, word state and the queue;
// search registers return to length 1 and zero letters. No clearing pass.
module whole_word_search_line_stats
  import wws_pkg::*;
#(
  parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
  parameter int CHUNK_BYTES    = DEF_CHUNK_BYTES,
  parameter int COUNT_BITS     = DEF_COUNT_BITS,
  parameter int DATA_BITS      = data_bits(COUNT_BITS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // text_byte
  input  logic                     in_tuser,   // action
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // line_number, word_index, line_count, occurrences, longest_length,
  // longest_line, zero fill
  output logic [DATA_BITS-1:0]     out_tdata,
  output logic                     out_tuser,  // kind
  output logic                     out_tlast
);

  localparam int RES_W = DATA_BITS + 2;

  logic             in_fire;
  logic [RES_W-1:0] res0, res1, head;
  push_t            push;

  assign in_fire = in_tvalid && in_tready;

  wws_core #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS),
    .CHUNK_BYTES   (CHUNK_BYTES),
    .COUNT_BITS    (COUNT_BITS),
    .RES_W         (RES_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_fire  (in_fire),
    .in_action(in_tuser),
    .in_byte  (in_tdata),
    .res0     (res0),
    .res1     (res1),
    .push     (push)
  );

  wws_oq #(
    .RES_W(RES_W)
  ) u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res0      (res0),
    .res1      (res1),
    .push      (push),
    .space     (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .head      (head)
  );

  assign out_tdata = head[DATA_BITS-1:0];
  assign out_tuser = head[DATA_BITS];
  assign out_tlast = head[DATA_BITS+1];

endmodule

@@ rtl/core/wws_core.sv @@
// Per-byte chunking, word matching and line statistics.
module wws_core
  import wws_pkg::*;
#(
  parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
  parameter int CHUNK_BYTES    = DEF_CHUNK_BYTES,
  parameter int COUNT_BITS     = DEF_COUNT_BITS,
  parameter int RES_W          = data_bits(COUNT_BITS) + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_fire,
  input  logic                     in_action,
  input  logic [7:0]               in_byte,
  output logic [RES_W-1:0]         res0,
  output logic [RES_W-1:0]         res1,
  output push_t                    push
);

  localparam int DATA_BITS = RES_W - 2;
  localparam int PAD_BITS  = DATA_BITS - 4 * COUNT_BITS - WIDX_BITS - LEN_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [WIDX_BITS-1:0]  WIDX_MAX = '1;

  logic [POS_BITS-1:0]   word_len_r;
  logic [CHARS_BITS-1:0] chars_r;

  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic                  still_r, still_nxt;
  logic                  inword_r, inword_nxt;
  logic [WIDX_BITS-1:0]  wcnt_r, wcnt_nxt;
  logic [LEN_BITS-1:0]   clen_r, clen_nxt;
  logic [COUNT_BITS-1:0] ccnt_r, ccnt_nxt;
  logic [COUNT_BITS-1:0] mcnt_r, mcnt_nxt;
  logic [LEN_BITS-1:0]   blen_r, blen_nxt;
  logic [COUNT_BITS-1:0] bline_r, bline_nxt;

  logic                  is_end, letter, len_ok, chunk_close, word_close, hit;
  logic [COUNT_BITS-1:0] ccnt_a;
  logic [WIDX_BITS-1:0]  wcnt_a;
  logic                  inword_a, still_a;
  logic [POS_BITS-1:0]   pos_a;
  logic [LEN_BITS-1:0]   clen_inc, close_len;
  logic [7:0]            want;
  logic [DATA_BITS-1:0]  match_data, summ_data;
  logic [RES_W-1:0]      match_res, summ_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r <= POS_BITS'(1);
      chars_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORD_LENGTH: word_len_r <= cfg_wdata[POS_BITS-1:0];
        CFG_CHARS_LOW:   chars_r[CFG_DATA_BITS-1:0] <= cfg_wdata;
        CFG_CHARS_HIGH:  chars_r[CHARS_BITS-1:CFG_DATA_BITS] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign is_end = (in_action == ACT_END);
  assign letter = is_letter(in_byte);
  assign len_ok = (word_len_r != '0) && (word_len_r <= POS_BITS'(MAX_WORD_CHARS));

  always_comb begin
    // open a chunk on its first byte
    if (!is_end && (clen_r == '0)) begin
      ccnt_a   = (ccnt_r == CNT_MAX) ? ccnt_r : ccnt_r + 1'b1;
      wcnt_a   = '0;
      inword_a = 1'b0;
    end else begin
      ccnt_a   = ccnt_r;
      wcnt_a   = wcnt_r;
      inword_a = inword_r;
    end
    pos_a   = pos_r;
    still_a = still_r;
    want    = chars_r[{pos_r[3:0], 3'b000} +: 8];
    if (!is_end && letter) begin
      if (!inword_a) begin
        pos_a   = '0;
        still_a = 1'b1;
        want    = chars_r[7:0];
      end
      if ((pos_a < word_len_r) && (pos_a < POS_BITS'(MAX_WORD_CHARS))) begin
        if (in_byte != want) still_a = 1'b0;
        pos_a = pos_a + 1'b1;
      end else begin
        still_a = 1'b0;
      end
      inword_a = 1'b1;
    end

    clen_inc    = clen_r + 1'b1;
    chunk_close = is_end ? (clen_r != '0)
                         : ((in_byte == NEWLINE) || (clen_inc >= LEN_BITS'(CHUNK_BYTES)));
    close_len   = is_end ? clen_r : clen_inc;
    word_close  = chunk_close || (!is_end && !letter);
    hit         = word_close && inword_a && still_a && len_ok && (pos_a == word_len_r);

    mcnt_nxt   = (hit && (mcnt_r != CNT_MAX)) ? mcnt_r + 1'b1 : mcnt_r;
    wcnt_nxt   = (word_close && inword_a && (wcnt_a != WIDX_MAX)) ? wcnt_a + 1'b1 : wcnt_a;
    inword_nxt = inword_a && !word_close;
    pos_nxt    = pos_a;
    still_nxt  = still_a;
    ccnt_nxt   = ccnt_a;
    clen_nxt   = chunk_close ? '0 : close_len;
    blen_nxt   = blen_r;
    bline_nxt  = bline_r;
    if (chunk_close && (close_len > blen_r)) begin
      blen_nxt  = close_len;
      bline_nxt = ccnt_a;
    end

    match_data = {{PAD_BITS{1'b0}}, COUNT_BITS'(0), LEN_BITS'(0), COUNT_BITS'(0),
                  COUNT_BITS'(0), wcnt_a, ccnt_a};
    summ_data  = {{PAD_BITS{1'b0}}, bline_nxt, blen_nxt, mcnt_nxt, ccnt_a,
                  WIDX_BITS'(0), COUNT_BITS'(0)};
    // result word: {last, kind, data}
    match_res  = {!is_end, KIND_MATCH, match_data};
    summ_res   = {1'b1, KIND_SUMMARY, summ_data};

    res0    = hit ? match_res : summ_res;
    res1    = summ_res;
    push.v0 = in_fire && (hit || is_end);
    push.v1 = in_fire && hit && is_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && is_end)) begin
      pos_r    <= '0;
      still_r  <= 1'b1;
      inword_r <= 1'b0;
      wcnt_r   <= '0;
      clen_r   <= '0;
      ccnt_r   <= '0;
      mcnt_r   <= '0;
      blen_r   <= '0;
      bline_r  <= '0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      still_r  <= still_nxt;
      inword_r <= inword_nxt;
      wcnt_r   <= wcnt_nxt;
      clen_r   <= clen_nxt;
      ccnt_r   <= ccnt_nxt;
      mcnt_r   <= mcnt_nxt;
      blen_r   <= blen_nxt;
      bline_r  <= bline_nxt;
    end
  end

endmodule

@@ rtl/core/wws_oq.sv @@
// Four-entry result queue that takes up to two words per cycle.
module wws_oq
  import wws_pkg::*;
#(
  parameter int RES_W = data_bits(DEF_COUNT_BITS) + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RES_W-1:0] res0,
  input  logic [RES_W-1:0] res1,
  input  push_t            push,
  output logic             space,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [RES_W-1:0] head
);

  `include "whole_word_search_line_stats_defines.svh"

  logic [RES_W-1:0]       mem_r [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wp_r, rp_r;
  logic [OQ_CNT_BITS-1:0] cnt_r, cnt_nxt, push_n;
  logic                   pop;

  assign push_n     = push.v1 ? OQ_CNT_BITS'(2) : (push.v0 ? OQ_CNT_BITS'(1) : '0);
  assign pop        = out_tvalid && out_tready;
  assign cnt_nxt    = cnt_r + push_n - OQ_CNT_BITS'(pop);
  // room for a full two-word burst
  assign space      = (cnt_r <= OQ_CNT_BITS'(OQ_DEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wp_r] <= res0;
    if (push.v1) mem_r[wp_r + 1'b1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n[OQ_PTR_BITS-1:0];
      rp_r  <= rp_r + OQ_PTR_BITS'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  `WWS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= OQ_CNT_BITS'(OQ_DEPTH), "result queue overflow")
  `WWS_ASSERT_NOW(a_push_room, push.v0, space, "result pushed without room for a burst")
  `WWS_ASSERT_NEXT(a_pop_drain, pop && !push.v0, cnt_r == $past(cnt_r) - 1'b1,
                   "queue count did not drop after a lone pop")

endmodule
